/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the radix conversion RTL.
// Included by files that check their own control logic; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every enabled clock edge.
`define RCDS_ASSERT_ALW(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) \
    else $error("%m: check failed");

// Consequent must hold in the same cycle as the antecedent.
`define RCDS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Consequent must hold in the cycle after the antecedent.
`define RCDS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* hw/rtl/rcds_pkg.sv */
// Types, constants and the digit-to-ASCII function for the radix converter.
// No dependencies; used by all files of the block but rcds_ram and the macros.
package rcds_pkg;

  localparam int unsigned VALUE_W = 32;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned MAX_RESULTS = 32;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] DEC_MAX   = 6'd9;
  localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0]  CHAR_A    = 8'h41;

  typedef struct packed {
    logic load;
    logic div_step;
    logic push;
    logic pop_rd;
    logic emit_digit;
    logic emit_err;
  } rcds_cmd_t;

  typedef struct packed {
    logic radix_ok;
    logic q_zero;
    logic step_last;
    logic sp_zero;
    logic out_free;
  } rcds_sts_t;

  function automatic logic [CHAR_W-1:0] to_ascii(input logic [RADIX_W-1:0] rem);
    logic [CHAR_W-1:0] rem_ext;
    rem_ext = {2'b00, rem};
    if (rem <= DEC_MAX) begin
      return CHAR_ZERO + rem_ext;
    end else begin
      return CHAR_A + (rem_ext - {2'b00, DEC_MAX} - 8'd1);
    end
  endfunction

endpackage

/* hw/rtl/rcds_if.sv */
// Valid/ready channel interfaces for the radix converter: input and result beats.
// Depends on rcds_pkg for field widths.
interface rcds_in_if;
  logic                           valid;
  logic                           ready;
  logic [rcds_pkg::VALUE_W-1:0]   value;
  logic [rcds_pkg::RADIX_W-1:0]   radix;

  modport source (output valid, value, radix, input ready);
  modport sink (input valid, value, radix, output ready);
endinterface

interface rcds_out_if;
  logic                           valid;
  logic                           ready;
  logic [rcds_pkg::CHAR_W-1:0]    digit_char;
  logic                           last_digit;
  logic                           radix_error;

  modport source (output valid, digit_char, last_digit, radix_error, input ready);
  modport sink (input valid, digit_char, last_digit, radix_error, output ready);
endinterface

/* hw/rtl/rcds_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcds_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* hw/rtl/rcds_dp.sv */
// Datapath: serial restoring divider, digit stack with pointer, output register.
// Depends on rcds_pkg, rcds_if, rcds_ram and assert_macros.svh.
`include "assert_macros.svh"

module rcds_dp #(
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [rcds_pkg::VALUE_W-1:0] in_value,
  input  logic [rcds_pkg::RADIX_W-1:0] in_radix,
  input  rcds_pkg::rcds_cmd_t          cmd_i,
  output rcds_pkg::rcds_sts_t          sts_o,
  rcds_out_if.source                   out_ch
);

  localparam int unsigned QW  = (VALUE_BITS < rcds_pkg::VALUE_W) ? VALUE_BITS
                                                                  : rcds_pkg::VALUE_W;
  localparam int unsigned CAP = (STACK_DEPTH < rcds_pkg::MAX_RESULTS) ? STACK_DEPTH
                                                                     : rcds_pkg::MAX_RESULTS;
  localparam int unsigned CW  = $clog2(QW);
  localparam int unsigned SPW = $clog2(CAP + 1);
  localparam int unsigned AW  = $clog2(CAP);
  localparam int unsigned RW  = rcds_pkg::RADIX_W;

  logic [QW-1:0]  q_r, q_nxt;
  logic [RW-1:0]  rem_r, rem_nxt;
  logic [RW-1:0]  radix_r, radix_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           out_valid_r, out_valid_nxt;
  logic [rcds_pkg::CHAR_W-1:0] digit_r, digit_nxt;
  logic           last_r, last_nxt;
  logic           err_r, err_nxt;

  logic [RW:0]    sh;
  logic [RW:0]    diff;
  logic           ge;
  logic           room;
  logic [SPW-1:0] sp_dec;
  logic [rcds_pkg::CHAR_W-1:0] rd_data;
  logic           out_free;

  assign sh     = {rem_r, q_r[QW-1]};
  assign ge     = sh >= {1'b0, radix_r};
  assign diff   = sh - {1'b0, radix_r};
  assign room   = sp_r < SPW'(CAP);
  assign sp_dec = sp_r - 1'b1;
  assign out_free = !out_valid_r || out_ch.ready;

  rcds_ram #(
    .WIDTH (rcds_pkg::CHAR_W),
    .DEPTH (CAP)
  ) u_stack (
    .clk     (clk),
    .wr_en   (cmd_i.push && room),
    .wr_addr (sp_r[AW-1:0]),
    .wr_data (rcds_pkg::to_ascii(rem_r)),
    .rd_en   (cmd_i.pop_rd),
    .rd_addr (sp_dec[AW-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    q_nxt         = q_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    cnt_nxt       = cnt_r;
    sp_nxt        = sp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    digit_nxt     = digit_r;
    last_nxt      = last_r;
    err_nxt       = err_r;
    if (cmd_i.load) begin
      q_nxt     = in_value[QW-1:0];
      rem_nxt   = '0;
      radix_nxt = in_radix;
      cnt_nxt   = '0;
      sp_nxt    = '0;
    end
    if (cmd_i.div_step) begin
      q_nxt   = {q_r[QW-2:0], ge};
      rem_nxt = ge ? diff[RW-1:0] : sh[RW-1:0];
      cnt_nxt = cnt_r + 1'b1;
    end
    if (cmd_i.push) begin
      rem_nxt = '0;
      cnt_nxt = '0;
      if (room) begin
        sp_nxt = sp_r + 1'b1;
      end
    end
    if (cmd_i.pop_rd) begin
      sp_nxt = sp_dec;
    end
    if (cmd_i.emit_digit) begin
      out_valid_nxt = 1'b1;
      digit_nxt     = rd_data;
      last_nxt      = sp_r == '0;
      err_nxt       = 1'b0;
    end
    if (cmd_i.emit_err) begin
      out_valid_nxt = 1'b1;
      digit_nxt     = '0;
      last_nxt      = 1'b1;
      err_nxt       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r        <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      q_r         <= '0;
    end else begin
      sp_r        <= sp_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      q_r         <= q_nxt;
    end
    rem_r   <= rem_nxt;
    radix_r <= radix_nxt;
    digit_r <= digit_nxt;
    last_r  <= last_nxt;
    err_r   <= err_nxt;
  end

  assign sts_o.radix_ok  = (in_radix >= rcds_pkg::RADIX_MIN) &&
                           (in_radix <= rcds_pkg::RADIX_MAX);
  assign sts_o.q_zero    = q_r == '0;
  assign sts_o.step_last = cnt_r == CW'(QW - 1);
  assign sts_o.sp_zero   = sp_r == '0;
  assign sts_o.out_free  = out_free;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.digit_char  = digit_r;
  assign out_ch.last_digit  = last_r;
  assign out_ch.radix_error = err_r;

  `RCDS_ASSERT_ALW(a_sp_cap, clk, rst_n, sp_r <= SPW'(CAP))
  `RCDS_ASSERT_IMP(a_emit_free, clk, rst_n, cmd_i.emit_digit || cmd_i.emit_err, out_free)
  `RCDS_ASSERT_IMP(a_pop_nonempty, clk, rst_n, cmd_i.pop_rd, sp_r != '0)
  `RCDS_ASSERT_NXT(a_push_grow, clk, rst_n, cmd_i.push && room, sp_r == $past(sp_r) + 1'b1)

endmodule

/* hw/rtl/rcds_ctrl.sv */
// Controller FSM: sequences load, divide, push, pop and emit for one item.
// Depends on rcds_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rcds_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rcds_pkg::rcds_sts_t sts_i,
  output rcds_pkg::rcds_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_FIRST,
    S_DIV,
    S_PUSH,
    S_POP_RD,
    S_POP_OUT,
    S_ERR
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (sts_i.radix_ok) begin
            cmd_o.load = 1'b1;
            state_nxt  = S_FIRST;
          end else begin
            state_nxt  = S_ERR;
          end
        end
      end
      S_FIRST: begin
        if (sts_i.q_zero) begin
          cmd_o.push = 1'b1;
          state_nxt  = S_POP_RD;
        end else begin
          state_nxt  = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) begin
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        cmd_o.push = 1'b1;
        state_nxt  = sts_i.q_zero ? S_POP_RD : S_DIV;
      end
      S_POP_RD: begin
        cmd_o.pop_rd = 1'b1;
        state_nxt    = S_POP_OUT;
      end
      S_POP_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          state_nxt        = sts_i.sp_zero ? S_IDLE : S_POP_RD;
        end
      end
      S_ERR: begin
        if (sts_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == S_IDLE;

  `RCDS_ASSERT_ALW(a_cmd_onehot, clk, rst_n, $onehot0(cmd_o))
  `RCDS_ASSERT_NXT(a_pop_then_out, clk, rst_n, cmd_o.pop_rd, state_r == S_POP_OUT)
  `RCDS_ASSERT_NXT(a_err_to_idle, clk, rst_n, cmd_o.emit_err, state_r == S_IDLE)

endmodule

/* hw/rtl/radix_conversion_digit_stack_core.sv */
// Top level of the radix converter: controller FSM plus datapath.
// Depends on rcds_pkg, rcds_if, rcds_ctrl, rcds_dp (and rcds_ram below it).
//
//  channel  dir  handshake     beat contents
//  in_ch    in   valid/ready   value[31:0], radix[5:0]
//  out_ch   out  valid/ready   digit_char[7:0], last_digit, radix_error
//
// One item at a time. Each digit is one pass of the serial divider over the low
// min(VALUE_BITS,32) bits (one quotient bit per cycle, then the push) and is
// then popped through the stack RAM's registered read (S_POP_RD, S_POP_OUT).
// Bad radix: one error beat. Zero value: one '0' beat.
// rst_n is synchronous, active low; no clearing pass, the stack is only read
// after being written. A stalled out_ch holds the pop sequence in place.
module radix_conversion_digit_stack_core #(
  parameter int unsigned VALUE_BITS  = 32,
  parameter int unsigned STACK_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  rcds_in_if.sink     in_ch,
  rcds_out_if.source  out_ch
);

  rcds_pkg::rcds_cmd_t cmd;
  rcds_pkg::rcds_sts_t sts;
  logic                in_ready;

  rcds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  rcds_dp #(
    .VALUE_BITS  (VALUE_BITS),
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_value (in_ch.value),
    .in_radix (in_ch.radix),
    .cmd_i    (cmd),
    .sts_o    (sts),
    .out_ch   (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule

/* bench/rcds_digit_checker.sv */
`timescale 1ns / 100ps
// Checker for the radix converter: watches both channels, predicts the digit beats.
// Depends on rcds_pkg and the rcds_in_if / rcds_out_if interfaces.
module rcds_digit_checker (
  input  logic clk,
  input  logic rst_n,
  rcds_in_if   in_mon,
  rcds_out_if  out_mon,
  output int   fail_count,
  output int   pending
);

  typedef struct packed {
    logic [rcds_pkg::CHAR_W-1:0] digit_char;
    logic                        last_digit;
    logic                        radix_error;
  } digit_beat_t;

  digit_beat_t digits_due[$];
  digit_beat_t got_beat;
  digit_beat_t want_beat;

  // Digits of one conversion, most significant first.
  function automatic void queue_digits(input logic [rcds_pkg::VALUE_W-1:0] num,
                                       input logic [rcds_pkg::RADIX_W-1:0] base);
    logic [rcds_pkg::CHAR_W-1:0]  chars[$];
    logic [rcds_pkg::VALUE_W-1:0] quot;
    logic [rcds_pkg::VALUE_W-1:0] base_ext;
    logic [rcds_pkg::VALUE_W-1:0] rem;
    digit_beat_t                  beat;
    if (base < rcds_pkg::RADIX_MIN || base > rcds_pkg::RADIX_MAX) begin
      beat.digit_char  = '0;
      beat.last_digit  = 1'b1;
      beat.radix_error = 1'b1;
      digits_due.push_back(beat);
    end else begin
      quot     = num;
      base_ext = rcds_pkg::VALUE_W'(base);
      do begin
        rem = quot % base_ext;
        if (chars.size() < rcds_pkg::MAX_RESULTS) begin
          if (rem < 10) begin
            chars.push_back(rcds_pkg::CHAR_ZERO + rcds_pkg::CHAR_W'(rem));
          end else begin
            chars.push_back(rcds_pkg::CHAR_A + rcds_pkg::CHAR_W'(rem - 10));
          end
        end
        quot = quot / base_ext;
      end while (quot != 0);
      for (int i = chars.size() - 1; i >= 0; i--) begin
        beat.digit_char  = chars[i];
        beat.last_digit  = (i == 0);
        beat.radix_error = 1'b0;
        digits_due.push_back(beat);
      end
    end
  endfunction

  initial begin
    fail_count = 0;
    pending    = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) begin
        queue_digits(in_mon.value, in_mon.radix);
      end
      if (out_mon.valid && out_mon.ready) begin
        got_beat.digit_char  = out_mon.digit_char;
        got_beat.last_digit  = out_mon.last_digit;
        got_beat.radix_error = out_mon.radix_error;
        if (digits_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("unexpected beat: char %h last %b err %b",
                     got_beat.digit_char, got_beat.last_digit, got_beat.radix_error);
          end
        end else begin
          want_beat = digits_due.pop_front();
          if (got_beat.digit_char !== want_beat.digit_char ||
              got_beat.last_digit !== want_beat.last_digit ||
              got_beat.radix_error !== want_beat.radix_error) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("mismatch: char exp %h got %h, last exp %b got %b, err exp %b got %b",
                       want_beat.digit_char, got_beat.digit_char,
                       want_beat.last_digit, got_beat.last_digit,
                       want_beat.radix_error, got_beat.radix_error);
            end
          end
        end
      end
      pending <= digits_due.size();
    end
  end

endmodule

/* bench/tb.sv */
`timescale 1ns / 100ps
// Top of the radix converter bench: clock, reset, stimulus, idling and verdict.
// Depends on rcds_pkg, the channel interfaces, the core and rcds_digit_checker.
module tb;

  localparam int LIMIT     = 3_000_000;
  localparam int HOLD_LEN  = 3000;
  localparam int PER_PHASE = 85;

  typedef enum int {PH_BURST, PH_SEND_GAPS, PH_RECV_STALLS, PH_BOTH} idle_phase_t;

  logic        clk;
  logic        rst_n;
  idle_phase_t phase;
  logic        hold_go;
  logic        out_hold;
  int          fail_count;
  int          pending;
  int          cycles;

  rcds_in_if  in_ch ();
  rcds_out_if out_ch ();

  radix_conversion_digit_stack_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  rcds_digit_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_ch),
    .out_mon   (out_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  function automatic int send_idle_pct(idle_phase_t p);
    case (p)
      PH_SEND_GAPS: return 64;
      PH_BOTH:      return 36;
      default:      return 0;
    endcase
  endfunction

  function automatic int recv_stall_pct(idle_phase_t p);
    case (p)
      PH_RECV_STALLS: return 64;
      PH_BOTH:        return 36;
      default:        return 0;
    endcase
  endfunction

  // receiver
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= !out_hold && ($urandom_range(0, 99) >= recv_stall_pct(phase));
    end
  end

  // long receiver hold-off so the core backs up and stalls its input
  initial begin
    out_hold = 1'b0;
    wait (hold_go);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_LEN) @(posedge clk);
    out_hold <= 1'b0;
  end

  task automatic send_beat(input logic [rcds_pkg::VALUE_W-1:0] num,
                           input logic [rcds_pkg::RADIX_W-1:0] base);
    while ($urandom_range(0, 99) < send_idle_pct(phase)) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= num;
    in_ch.radix <= base;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic logic [rcds_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2, 3:    return rcds_pkg::VALUE_W'($urandom_range(0, 1295));
      4, 5:    return $urandom >> $urandom_range(0, 31);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [rcds_pkg::RADIX_W-1:0] pick_radix();
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        return rcds_pkg::RADIX_W'($urandom_range(0, 1));
      end
      return rcds_pkg::RADIX_W'($urandom_range(37, 63));
    end
    return rcds_pkg::RADIX_W'($urandom_range(2, 36));
  endfunction

  initial begin
    rst_n       = 1'b0;
    phase       = PH_BURST;
    hold_go     = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.radix = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero, bad radices, extremes of value and radix
    send_beat('0, 6'd10);
    send_beat('0, 6'd2);
    send_beat('0, 6'd36);
    send_beat(32'd12345, 6'd0);
    send_beat('1, 6'd1);
    send_beat('0, 6'd37);
    send_beat(32'h8000_0000, 6'd63);
    send_beat('1, 6'd2);
    send_beat('1, 6'd36);
    send_beat('1, 6'd10);
    send_beat('1, 6'd16);
    send_beat(32'hDEAD_BEEF, 6'd16);
    send_beat(32'd1, 6'd2);
    send_beat(32'd1, 6'd36);
    send_beat(32'd36, 6'd36);
    send_beat(32'd35, 6'd36);
    send_beat(32'd34, 6'd35);
    send_beat(32'd9, 6'd10);
    send_beat(32'd10, 6'd11);
    send_beat(32'h8000_0000, 6'd2);
    send_beat(32'h5555_5555, 6'd3);
    send_beat(32'd1295, 6'd36);

    // random, one idling pattern per phase
    for (int p = 0; p < 4; p++) begin
      phase <= idle_phase_t'(p);
      if (p == 0) begin
        hold_go <= 1'b1;
      end
      for (int i = 0; i < PER_PHASE; i++) begin
        send_beat(pick_value(), pick_radix());
      end
    end
    in_ch.valid <= 1'b0;
    phase       <= PH_BURST;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
